FILE: rtl/core/bdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types and constants of the button debounce and click detector.
// ----------------------------------------------------------------------------
package bdc_pkg;

    localparam int unsigned TimeWidth = 32;
    localparam int unsigned CfgWidth  = 16;
    localparam int unsigned AddrWidth = 4;
    localparam int unsigned DataWidth = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] RegDebounce  = 2'd0;
    localparam logic [1:0] RegClickGap  = 2'd1;
    localparam logic [1:0] RegLongPress = 2'd2;
    localparam logic [1:0] RegRepeat    = 2'd3;

    localparam logic [CfgWidth-1:0] DebounceReset  = 16'd10;
    localparam logic [CfgWidth-1:0] ClickGapReset  = 16'd400;
    localparam logic [CfgWidth-1:0] LongPressReset = 16'd800;
    localparam logic [CfgWidth-1:0] RepeatReset    = 16'd0;

    typedef struct packed {
        logic [CfgWidth-1:0] lockout_ms;
        logic [CfgWidth-1:0] double_click_gap_ms;
        logic [CfgWidth-1:0] long_press_ms;
        logic [CfgWidth-1:0] long_repeat_ms;
    } bdc_cfg_t;

    typedef struct packed {
        logic level;
        logic changed;
        logic press_edge;
        logic release_edge;
        logic long_start;
        logic long_during;
        logic long_stop;
        logic single_click;
        logic double_click;
    } bdc_result_t;

endpackage

FILE: rtl/core/bdc_poll_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_poll_if
// Valid/ready channel carrying one poll of the raw pin and the time.
// ----------------------------------------------------------------------------
interface bdc_poll_if;

    logic        valid;
    logic        ready;
    logic        pin_level;
    logic [31:0] now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);

endinterface

FILE: rtl/core/bdc_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_result_if
// Valid/ready channel carrying the debounced level and the event flags.
// ----------------------------------------------------------------------------
interface bdc_result_if;

    logic valid;
    logic ready;
    logic level;
    logic changed;
    logic press_edge;
    logic release_edge;
    logic long_start;
    logic long_during;
    logic long_stop;
    logic single_click;
    logic double_click;

    modport source (
        output valid, output level, output changed, output press_edge,
        output release_edge, output long_start, output long_during,
        output long_stop, output single_click, output double_click,
        input ready
    );
    modport sink (
        input valid, input level, input changed, input press_edge,
        input release_edge, input long_start, input long_during,
        input long_stop, input single_click, input double_click,
        output ready
    );

endinterface

FILE: rtl/core/button_debounce_click_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_click_detector
// Lockout debouncer with long press, single and double click detection.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Transfer on         | Carries
//  --------+-----------+---------------------+------------------------------
//  poll    | sink      | valid && ready      | pin_level, now_ms
//  result  | source    | valid && ready      | level and eight event flags
//  APB     | slave     | psel&penable&pwrite | four 16-bit timing registers
//
//  Every poll gives exactly one result. A poll is held in the input register,
//  is classified by the engine, and its result is captured in the output
//  register; one poll is taken every cycle while the result is not stalled.
//  The state update in the engine is a single pass of compares on 32-bit
//  elapsed times. A stalled result holds the output register; the input
//  register still takes one poll and then holds it. Reset clears the
//  debounce state to released with no lockout and the registers to their
//  default timings.
//
module button_debounce_click_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdc_pkg::AddrWidth-1:0] paddr,
    input  logic [bdc_pkg::DataWidth-1:0] pwdata,
    output logic [bdc_pkg::DataWidth-1:0] prdata,
    output logic                          pready,
    bdc_poll_if.sink                      poll,
    bdc_result_if.source                  result
);
    import bdc_pkg::*;

    bdc_cfg_t             cfg;
    bdc_result_t          res_comb;
    bdc_result_t          res_reg;

    // Input register: one poll waiting for the engine.
    logic                 in_valid_reg, in_valid_next;
    logic                 in_pin_reg;
    logic [TimeWidth-1:0] in_now_reg;

    // Output register: one result waiting for its transfer.
    logic                 out_valid_reg, out_valid_next;

    logic                 advance;
    logic                 poll_take;

    bdc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The engine commits its state exactly when the held poll moves on to
    // the output register, so the next poll always sees the updated state.
    bdc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (in_valid_reg && advance),
        .pin_level (in_pin_reg),
        .now_ms    (in_now_reg),
        .res       (res_comb)
    );

    // The output slot frees up when empty or when its result is taken.
    assign advance    = !out_valid_reg || result.ready;
    assign poll.ready = !in_valid_reg || advance;
    assign poll_take  = poll.valid && poll.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (poll.ready)
            in_valid_next = poll.valid;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (poll_take)
        begin
            in_pin_reg <= poll.pin_level;
            in_now_reg <= poll.now_ms;
        end
        if (advance && in_valid_reg)
        begin
            res_reg <= res_comb;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.level        = res_reg.level;
    assign result.changed      = res_reg.changed;
    assign result.press_edge   = res_reg.press_edge;
    assign result.release_edge = res_reg.release_edge;
    assign result.long_start   = res_reg.long_start;
    assign result.long_during  = res_reg.long_during;
    assign result.long_stop    = res_reg.long_stop;
    assign result.single_click = res_reg.single_click;
    assign result.double_click = res_reg.double_click;

endmodule

FILE: rtl/core/bdc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_cfg_regs
// APB register file holding the four timing registers.
// ----------------------------------------------------------------------------
module bdc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdc_pkg::AddrWidth-1:0] paddr,
    input  logic [bdc_pkg::DataWidth-1:0] pwdata,
    output logic [bdc_pkg::DataWidth-1:0] prdata,
    output logic                          pready,
    output bdc_pkg::bdc_cfg_t             cfg
);
    import bdc_pkg::*;

    bdc_cfg_t            cfg_reg;
    bdc_cfg_t            cfg_next;
    logic [1:0]          reg_index;
    logic [CfgWidth-1:0] rd_value;

    assign reg_index = paddr[3:2];
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (reg_index)
                RegDebounce:  cfg_next.lockout_ms          = pwdata[CfgWidth-1:0];
                RegClickGap:  cfg_next.double_click_gap_ms = pwdata[CfgWidth-1:0];
                RegLongPress: cfg_next.long_press_ms       = pwdata[CfgWidth-1:0];
                RegRepeat:    cfg_next.long_repeat_ms      = pwdata[CfgWidth-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            RegDebounce:  rd_value = cfg_reg.lockout_ms;
            RegClickGap:  rd_value = cfg_reg.double_click_gap_ms;
            RegLongPress: rd_value = cfg_reg.long_press_ms;
            RegRepeat:    rd_value = cfg_reg.long_repeat_ms;
            default:      rd_value = '0;
        endcase
    end

    assign prdata = {{(DataWidth-CfgWidth){1'b0}}, rd_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lockout_ms          <= DebounceReset;
            cfg_reg.double_click_gap_ms <= ClickGapReset;
            cfg_reg.long_press_ms       <= LongPressReset;
            cfg_reg.long_repeat_ms      <= RepeatReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/bdc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_engine
// Debounce and press classification state with its single-pass update.
// ----------------------------------------------------------------------------
module bdc_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bdc_pkg::bdc_cfg_t             cfg,
    input  logic                          fire,
    input  logic                          pin_level,
    input  logic [bdc_pkg::TimeWidth-1:0] now_ms,
    output bdc_pkg::bdc_result_t          res
);
    import bdc_pkg::*;

    logic                 stable_reg, stable_next;
    logic                 lockout_reg, lockout_next;
    logic                 long_reg, long_next;
    logic                 pending_reg, pending_next;
    logic [TimeWidth-1:0] edge_time_reg, edge_time_next;
    logic [TimeWidth-1:0] press_time_reg, press_time_next;
    logic [TimeWidth-1:0] repeat_time_reg, repeat_time_next;
    logic [TimeWidth-1:0] click_time_reg, click_time_next;

    logic [TimeWidth-1:0] d_edge, d_press, d_repeat, d_click;
    logic                 lock_mid, accept, level_new;
    logic                 long_mid, long_hold, click_now;
    logic                 pend_mid;

    // All elapsed times are taken against the stored stamps in parallel.
    assign d_edge   = now_ms - edge_time_reg;
    assign d_press  = now_ms - press_time_reg;
    assign d_repeat = now_ms - repeat_time_reg;
    assign d_click  = now_ms - click_time_reg;

    always_comb
    begin
        res = '0;

        // Lockout expiry, then edge acceptance.
        lock_mid  = lockout_reg &&
                    (d_edge < {{(TimeWidth-CfgWidth){1'b0}}, cfg.lockout_ms});
        accept    = !lock_mid && (pin_level != stable_reg);
        level_new = accept ? ~stable_reg : stable_reg;
        res.level        = level_new;
        res.changed      = accept;
        res.press_edge   = accept && !level_new;
        res.release_edge = accept && level_new;

        lockout_next   = accept || lock_mid;
        edge_time_next = accept ? now_ms : edge_time_reg;
        press_time_next = res.press_edge ? now_ms : press_time_reg;

        // A fresh press has zero elapsed hold time and no long press yet.
        long_mid       = res.press_edge ? 1'b0 : long_reg;
        res.long_start = !level_new && !long_mid &&
                         ((res.press_edge ? '0 : d_press) >=
                          {{(TimeWidth-CfgWidth){1'b0}}, cfg.long_press_ms});
        long_hold      = long_mid || res.long_start;
        res.long_during = !level_new && long_mid && !res.long_start &&
                          (cfg.long_repeat_ms != '0) &&
                          (d_repeat >= {{(TimeWidth-CfgWidth){1'b0}}, cfg.long_repeat_ms});

        if (res.long_start || res.long_during)
            repeat_time_next = now_ms;
        else if (res.press_edge)
            repeat_time_next = '0;
        else
            repeat_time_next = repeat_time_reg;

        // Release handling: end a long press or count a click.
        pend_mid        = pending_reg;
        click_time_next = click_time_reg;
        click_now       = 1'b0;
        res.long_stop   = res.release_edge && long_reg;
        long_next       = res.long_stop ? 1'b0 : long_hold;
        if (res.release_edge)
        begin
            priority if (long_reg)
            begin
                pend_mid        = 1'b0;
                click_time_next = '0;
            end
            else if (!pending_reg)
            begin
                pend_mid        = 1'b1;
                click_time_next = now_ms;
                click_now       = 1'b1;
            end
            else if (d_click <= {{(TimeWidth-CfgWidth){1'b0}}, cfg.double_click_gap_ms})
            begin
                res.double_click = 1'b1;
                pend_mid         = 1'b0;
                click_time_next  = '0;
            end
            else
            begin
                res.single_click = 1'b1;
                pend_mid         = 1'b1;
                click_time_next  = now_ms;
                click_now        = 1'b1;
            end
        end

        // Click window timeout; a window opened on this poll has zero age.
        pending_next = pend_mid;
        if (pend_mid && !click_now &&
            (d_click > {{(TimeWidth-CfgWidth){1'b0}}, cfg.double_click_gap_ms}))
        begin
            res.single_click = 1'b1;
            pending_next     = 1'b0;
            click_time_next  = '0;
        end

        stable_next = level_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg      <= 1'b1;
            lockout_reg     <= 1'b0;
            long_reg        <= 1'b0;
            pending_reg     <= 1'b0;
            edge_time_reg   <= '0;
            press_time_reg  <= '0;
            repeat_time_reg <= '0;
            click_time_reg  <= '0;
        end
        else if (fire)
        begin
            stable_reg      <= stable_next;
            lockout_reg     <= lockout_next;
            long_reg        <= long_next;
            pending_reg     <= pending_next;
            edge_time_reg   <= edge_time_next;
            press_time_reg  <= press_time_next;
            repeat_time_reg <= repeat_time_next;
            click_time_reg  <= click_time_next;
        end
    end

endmodule
